@@ rtl/mnls_pkg.sv @@
// shared types and constants for the markov note learner / sampler
// no dependencies; imported by every module of the block except mnls_div
package mnls_pkg;

    localparam int IN_TDATA_W  = 32;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 16;
    localparam int NOTE_W      = 7;
    localparam int VEL_W       = 7;
    localparam int RAND_W      = 16;
    localparam int OCT_W       = 3;
    localparam int PC_OUT_W    = 4;
    localparam int MIDI_W      = 7;

    localparam logic [NOTE_W-1:0] BREAK_NOTE    = 7'd21;
    localparam logic [OCT_W-1:0]  OCTAVE_RESET  = 3'd4;
    localparam logic [OCT_W-1:0]  OCTAVE_MIN    = 3'd1;
    localparam logic [4:0]        COL_HALF      = 5'd4;
    localparam logic [4:0]        COL_TWENTIETH_A = 5'd1;
    localparam logic [4:0]        COL_TWENTIETH_B = 5'd10;
    localparam logic [4:0]        COL_TWENTIETH_C = 5'd11;

    typedef enum logic [1:0] {
        KIND_RECORD = 2'd0,
        KIND_START  = 2'd1,
        KIND_FINISH = 2'd2,
        KIND_PLAY   = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_REC_WR,
        S_SUM_RD,
        S_SUM_ACC,
        S_NORM_CHK,
        S_NORM_RD,
        S_NORM_DIV,
        S_NORM_WAIT,
        S_ROW_NEXT,
        S_PLAY_RD,
        S_PLAY_CHK,
        S_EMIT
    } t_state;

    typedef enum logic {
        RD_REC,
        RD_TAB
    } t_rd_sel;

    typedef enum logic [1:0] {
        WR_INC,
        WR_QUO,
        WR_ONE
    } t_wr_sel;

    typedef struct packed {
        logic    load;
        logic    clear_table;
        logic    rec_update;
        logic    rec_off;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    wr_en;
        t_wr_sel wr_sel;
        logic    col_clr;
        logic    col_inc;
        logic    row_clr;
        logic    row_inc;
        logic    sum_clr;
        logic    sum_acc;
        logic    div_start;
        logic    play_load;
        logic    emit;
    } t_dp_cmd;

    typedef struct packed {
        t_kind kind;
        logic  recording;
        logic  vel_nz;
        logic  is_break;
        logic  prev_valid;
        logic  col_last;
        logic  row_last;
        logic  total_zero;
        logic  hit;
        logic  div_done;
        logic  out_free;
    } t_dp_stat;

endpackage

@@ rtl/mnls_ctrl.sv @@
// sequencer for record, clear, normalize and play-walk operations
// depends on mnls_pkg for state, command and status types
module mnls_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  mnls_pkg::t_dp_stat i_stat,
    output mnls_pkg::t_dp_cmd  o_cmd
);
    import mnls_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = i_rst_n;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_IDLE;
                case (i_stat.kind)
                    KIND_START: begin
                        o_cmd.clear_table = 1'b1;
                    end
                    KIND_RECORD: begin
                        if (i_stat.recording && i_stat.vel_nz) begin
                            if (!i_stat.is_break && i_stat.prev_valid) begin
                                o_cmd.rd_en  = 1'b1;
                                o_cmd.rd_sel = RD_REC;
                                n_state      = S_REC_WR;
                            end else begin
                                o_cmd.rec_update = 1'b1;
                            end
                        end
                    end
                    KIND_FINISH: begin
                        if (i_stat.recording) begin
                            o_cmd.rec_off = 1'b1;
                            o_cmd.row_clr = 1'b1;
                            o_cmd.col_clr = 1'b1;
                            o_cmd.sum_clr = 1'b1;
                            n_state       = S_SUM_RD;
                        end
                    end
                    KIND_PLAY: begin
                        if (!i_stat.recording) begin
                            o_cmd.play_load = 1'b1;
                            o_cmd.col_clr   = 1'b1;
                            o_cmd.sum_clr   = 1'b1;
                            n_state         = S_PLAY_RD;
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_REC_WR: begin
                o_cmd.wr_en      = 1'b1;
                o_cmd.wr_sel     = WR_INC;
                o_cmd.rec_update = 1'b1;
                n_state          = S_IDLE;
            end
            S_SUM_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_TAB;
                n_state      = S_SUM_ACC;
            end
            S_SUM_ACC: begin
                o_cmd.sum_acc = 1'b1;
                if (i_stat.col_last) begin
                    o_cmd.col_clr = 1'b1;
                    n_state       = S_NORM_CHK;
                end else begin
                    o_cmd.col_inc = 1'b1;
                    n_state       = S_SUM_RD;
                end
            end
            S_NORM_CHK: begin
                // empty row: all weight goes to entry 0, others already zero
                if (i_stat.total_zero) begin
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.wr_sel = WR_ONE;
                    n_state      = S_ROW_NEXT;
                end else begin
                    n_state = S_NORM_RD;
                end
            end
            S_NORM_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_TAB;
                n_state      = S_NORM_DIV;
            end
            S_NORM_DIV: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_NORM_WAIT;
            end
            S_NORM_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.wr_sel = WR_QUO;
                    if (i_stat.col_last) begin
                        o_cmd.col_clr = 1'b1;
                        n_state       = S_ROW_NEXT;
                    end else begin
                        o_cmd.col_inc = 1'b1;
                        n_state       = S_NORM_RD;
                    end
                end
            end
            S_ROW_NEXT: begin
                if (i_stat.row_last) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.row_inc = 1'b1;
                    o_cmd.col_clr = 1'b1;
                    o_cmd.sum_clr = 1'b1;
                    n_state       = S_SUM_RD;
                end
            end
            S_PLAY_RD: begin
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = RD_TAB;
                n_state      = S_PLAY_CHK;
            end
            S_PLAY_CHK: begin
                if (i_stat.hit) begin
                    n_state = S_EMIT;
                end else begin
                    o_cmd.sum_acc = 1'b1;
                    o_cmd.col_inc = 1'b1;
                    n_state       = i_stat.col_last ? S_EMIT : S_PLAY_RD;
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    a_no_play_while_rec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PLAY_RD) |-> !i_stat.recording)
        else $error("play walk running while recording");
`endif

endmodule

@@ rtl/mnls_div.sv @@
// restoring divider, one quotient bit per cycle, quotient known to fit Q_W bits
// standalone; used by mnls_dp for row normalization
module mnls_div #(
    parameter int NUM_W = 34,
    parameter int DEN_W = 21,
    parameter int Q_W   = 17
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_busy,
    output logic             o_done,
    output logic [Q_W-1:0]   o_quo
);
    localparam int CNT_W = $clog2(Q_W + 1);

    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [Q_W-1:0]   r_num_lo;
    logic [Q_W-1:0]   r_quo;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    assign trial = {r_rem, r_num_lo[Q_W-1]};
    assign diff  = trial - {1'b0, r_den};
    assign ge    = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(Q_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            // high part is below the divisor since the quotient fits Q_W bits
            r_rem    <= DEN_W'(i_num[NUM_W-1:Q_W]);
            r_num_lo <= i_num[Q_W-1:0];
            r_den    <= i_den;
        end else if (r_busy) begin
            r_rem    <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            r_num_lo <= r_num_lo << 1;
            r_quo    <= {r_quo[Q_W-2:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

@@ rtl/mnls_dp.sv @@
// datapath: item registers, weight memory with valid bits, counters,
// accumulator, divider and output register; depends on mnls_pkg and mnls_div
module mnls_dp #(
    parameter int CLASSES       = 12,
    parameter int FRACTION_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mnls_pkg::t_dp_cmd                   i_cmd,
    output mnls_pkg::t_dp_stat                  o_stat,
    input  logic [mnls_pkg::IN_TDATA_W-1:0]     i_item_data,
    input  logic [mnls_pkg::IN_TUSER_W-1:0]     i_item_kind,
    input  logic                                i_cfg_we,
    input  logic [mnls_pkg::OCT_W-1:0]          i_cfg_data,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [mnls_pkg::OUT_TDATA_W-1:0]    o_out_data
);
    import mnls_pkg::*;

    localparam int W      = FRACTION_BITS + 1;
    localparam int RW     = $clog2(CLASSES);
    localparam int CW     = $clog2(CLASSES + 1);
    localparam int DEPTH  = CLASSES * CLASSES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int TOT_W  = W + $clog2(CLASSES);
    localparam int NUM_W  = 2 * FRACTION_BITS + 2;

    localparam logic [W-1:0] ONE_Q = W'(64'd1 << FRACTION_BITS);
    localparam logic [W-1:0] W_HALF = W'((64'd1 << FRACTION_BITS) / 64'd2);
    localparam logic [W-1:0] W_TENTH =
        W'(((64'd1 << FRACTION_BITS) * 64'd10 + 64'd50) / 64'd100);
    localparam logic [W-1:0] W_TWENTIETH =
        W'(((64'd1 << FRACTION_BITS) * 64'd5 + 64'd50) / 64'd100);

    function automatic logic [RW-1:0] note_class(input logic [NOTE_W-1:0] n);
        logic [RW-1:0] res;
        res = '0;
        for (int i = 0; i < (1 << NOTE_W); i++) begin
            if (n == NOTE_W'(i)) begin
                res = RW'(i % CLASSES);
            end
        end
        return res;
    endfunction

    function automatic logic [W-1:0] preset_w(input logic [RW-1:0] c);
        logic [4:0] cc;
        logic [W-1:0] res;
        cc = 5'(c);
        if (cc == COL_HALF) begin
            res = W_HALF;
        end else if (cc == COL_TWENTIETH_A || cc == COL_TWENTIETH_B ||
                     cc == COL_TWENTIETH_C) begin
            res = W_TWENTIETH;
        end else begin
            res = W_TENTH;
        end
        return res;
    endfunction

    // latched item
    t_kind             r_kind;
    logic [NOTE_W-1:0] r_note;
    logic [VEL_W-1:0]  r_vel;
    logic              r_heard;
    logic [RAND_W-1:0] r_rnd;

    // control state
    logic              r_recording;
    logic              r_prev_valid;
    logic [RW-1:0]     r_prev;
    logic [RW-1:0]     r_cur_note;
    logic [OCT_W-1:0]  r_octave;
    logic              r_blank_zero;
    logic [DEPTH-1:0]  r_valid;

    // walk / sweep state
    logic [RW-1:0]     r_row;
    logic [CW-1:0]     r_col;
    logic [TOT_W-1:0]  r_sum;

    // memory and registered read
    logic [W-1:0]      r_mem [DEPTH];
    logic [W-1:0]      r_rd_q;
    logic              r_rd_valid;
    logic [RW-1:0]     r_rd_col;

    // output register
    logic                r_out_valid;
    logic [PC_OUT_W-1:0] r_out_pc;
    logic [MIDI_W-1:0]   r_out_midi;

    logic [RW-1:0]      cur;
    logic               vel_nz;
    logic               is_break;
    logic [ADDR_W-1:0]  rec_addr;
    logic [ADDR_W-1:0]  tab_addr;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  wr_addr;
    logic [W-1:0]       wr_data;
    logic [W-1:0]       w_rd;
    logic [FRACTION_BITS+RAND_W-1:0] rnd_wide;
    logic [FRACTION_BITS-1:0]        target;
    logic [TOT_W:0]     walk_sum;
    logic [NUM_W-1:0]   div_num;
    logic               div_busy;
    logic               div_done;
    logic [W-1:0]       div_quo;
    logic [OCT_W-1:0]   oct_eff;
    logic [7:0]         midi_wide;
    logic               out_free;

    assign cur      = note_class(r_note);
    assign vel_nz   = r_vel != '0;
    assign is_break = r_note == BREAK_NOTE;
    assign rec_addr = ADDR_W'(r_prev) * ADDR_W'(CLASSES) + ADDR_W'(cur);
    assign tab_addr = ADDR_W'(r_row) * ADDR_W'(CLASSES) + ADDR_W'(r_col[RW-1:0]);
    assign rd_addr  = (i_cmd.rd_sel == RD_REC) ? rec_addr : tab_addr;

    // entries not written since reset or start read as preset or zero
    always_comb begin
        if (r_rd_valid) begin
            w_rd = r_rd_q;
        end else if (r_blank_zero) begin
            w_rd = '0;
        end else begin
            w_rd = preset_w(r_rd_col);
        end
    end

    always_comb begin
        wr_addr = tab_addr;
        wr_data = ONE_Q;
        case (i_cmd.wr_sel)
            WR_INC: begin
                wr_addr = rec_addr;
                wr_data = (w_rd == '1) ? w_rd : w_rd + 1'b1;
            end
            WR_QUO: begin
                wr_data = div_quo;
            end
            WR_ONE: begin
                wr_data = ONE_Q;
            end
            default: begin
                wr_data = ONE_Q;
            end
        endcase
    end

    assign rnd_wide = {r_rnd, {FRACTION_BITS{1'b0}}};
    assign target   = rnd_wide[FRACTION_BITS+RAND_W-1:RAND_W];
    assign walk_sum = {1'b0, r_sum} + (TOT_W + 1)'(w_rd);

    // rounded fraction: (count << F + total / 2) / total
    assign div_num = (NUM_W'(w_rd) << FRACTION_BITS) + NUM_W'(r_sum >> 1);

    mnls_div #(
        .NUM_W (NUM_W),
        .DEN_W (TOT_W),
        .Q_W   (W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (r_sum),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign oct_eff   = (r_octave == '0) ? OCTAVE_MIN : r_octave;
    assign midi_wide = 8'(r_col) + 8'(oct_eff) * 8'(CLASSES);
    assign out_free  = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= t_kind'(i_item_kind);
            r_note  <= i_item_data[6:0];
            r_vel   <= i_item_data[13:7];
            r_heard <= i_item_data[14];
            r_rnd   <= i_item_data[30:15];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recording  <= 1'b0;
            r_prev_valid <= 1'b0;
            r_prev       <= '0;
            r_cur_note   <= '0;
            r_octave     <= OCTAVE_RESET;
            r_blank_zero <= 1'b0;
            r_valid      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_octave <= i_cfg_data;
            end
            if (i_cmd.clear_table) begin
                r_valid      <= '0;
                r_blank_zero <= 1'b1;
                r_recording  <= 1'b1;
                r_prev_valid <= 1'b0;
                r_prev       <= '0;
            end else if (i_cmd.wr_en) begin
                r_valid[wr_addr] <= 1'b1;
            end
            if (i_cmd.rec_off) begin
                r_recording <= 1'b0;
            end
            if (i_cmd.rec_update) begin
                if (is_break) begin
                    r_prev_valid <= 1'b0;
                end else begin
                    r_prev_valid <= 1'b1;
                    r_prev       <= cur;
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
                r_cur_note  <= (r_col == CW'(CLASSES)) ? '0 : r_col[RW-1:0];
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.row_clr) begin
            r_row <= '0;
        end else if (i_cmd.row_inc) begin
            r_row <= r_row + 1'b1;
        end else if (i_cmd.play_load) begin
            if (r_heard) begin
                r_row <= vel_nz ? cur : '0;
            end else begin
                r_row <= r_cur_note;
            end
        end
        if (i_cmd.col_clr) begin
            r_col <= '0;
        end else if (i_cmd.col_inc) begin
            r_col <= r_col + 1'b1;
        end
        if (i_cmd.sum_clr) begin
            r_sum <= '0;
        end else if (i_cmd.sum_acc) begin
            r_sum <= walk_sum[TOT_W-1:0];
        end
        if (i_cmd.emit) begin
            r_out_pc   <= PC_OUT_W'(r_col);
            r_out_midi <= midi_wide[MIDI_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_q     <= r_mem[rd_addr];
            r_rd_valid <= r_valid[rd_addr];
            r_rd_col   <= (i_cmd.rd_sel == RD_REC) ? cur : r_col[RW-1:0];
        end
    end

    always_comb begin
        o_stat.kind       = r_kind;
        o_stat.recording  = r_recording;
        o_stat.vel_nz     = vel_nz;
        o_stat.is_break   = is_break;
        o_stat.prev_valid = r_prev_valid;
        o_stat.col_last   = r_col == CW'(CLASSES - 1);
        o_stat.row_last   = r_row == RW'(CLASSES - 1);
        o_stat.total_zero = r_sum == '0;
        o_stat.hit        = walk_sum >= (TOT_W + 1)'(target);
        o_stat.div_done   = div_done;
        o_stat.out_free   = out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = {{(OUT_TDATA_W - PC_OUT_W - MIDI_W){1'b0}}, r_out_midi, r_out_pc};

`ifndef SYNTH
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!r_out_valid || i_out_ready))
        else $error("result overwrites a pending transaction");
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |-> !div_busy)
        else $error("divider restarted while busy");
    a_inc_rec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wr_en && i_cmd.wr_sel == WR_INC) |-> (r_recording && r_prev_valid))
        else $error("count update outside recording");
`endif

endmodule

@@ rtl/markov_note_learner_sampler_core.sv @@
// a start clears the table, a record note may update one count, a play walks up to
// CLASSES entries of a row, and a finish normalizes every row with the bit-serial divider;
// one transaction in flight, the result register frees the input while a result waits
// reset (synchronous, active low): table reads as preset weights, not recording,
// no previous note, current note 0, octave 4; no clearing pass is needed
module markov_note_learner_sampler_core #(
    parameter int CLASSES       = 12,
    parameter int FRACTION_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input stream
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [6:0] note, [13:7] velocity, [14] heard, [30:15] random, [31] zero
    input  logic [mnls_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // [1:0] kind
    input  logic [mnls_pkg::IN_TUSER_W-1:0]     i_s_axis_tuser,
    // result stream
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [3:0] pitch_class, [10:4] midi_note, [15:11] zero
    output logic [mnls_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    // octave register write
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mnls_pkg::OCT_W-1:0]          i_cfg_data
);
    import mnls_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // octave writes are taken whenever out of reset
    assign o_cfg_ready = i_rst_n;

    // controller: accepts one transaction and sequences the datapath
    mnls_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // datapath: weight memory, normalizer divider, play walk, result register
    mnls_dp #(
        .CLASSES       (CLASSES),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_item_data (i_s_axis_tdata),
        .i_item_kind (i_s_axis_tuser),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_data  (o_m_axis_tdata)
    );

endmodule

@@ tb/markov_note_learner_sampler_core_test.sv @@
// self-checking testbench for markov_note_learner_sampler_core: directed rows, then
// learn/play sessions with random content, checked against an in-bench transition table
// depends on rtl/mnls_pkg.sv and rtl/markov_note_learner_sampler_core.sv
module markov_note_learner_sampler_core_test;
    import mnls_pkg::*;

    localparam int CLASSES      = 12;
    localparam int FRAC         = 16;
    localparam int ONE_Q        = 1 << FRAC;
    localparam int COUNT_MAX    = (2 << FRAC) - 1;
    // a finish pass (row sums plus bit-serial divides) is the slowest thing the block does
    localparam int QUIET        = CLASSES * (2 * CLASSES + CLASSES * (FRAC + 5) + 2) + 100;
    localparam int HOLD_CYCLES  = 600;
    localparam int RANDOM_ITEMS = 1600;
    // one pair repeated back to back to pile up a single count
    localparam int PAIR_REPEATS = 40;

    // one input transaction, in field order
    typedef struct packed {
        t_kind               kind;
        logic [NOTE_W-1:0]   note;
        logic [VEL_W-1:0]    vel;
        logic                heard;
        logic [RAND_W-1:0]   rnd;
    } t_note_event;

    // one result transaction
    typedef struct packed {
        logic [PC_OUT_W-1:0] pc;
        logic [MIDI_W-1:0]   midi;
    } t_pick;

    // directed row: typed set means the expected pick is written into the row
    typedef struct packed {
        t_note_event ev;
        logic        typed;
        t_pick       want;
    } t_plan_row;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;   // [6:0] note, [13:7] velocity, [14] heard, [30:15] random
    logic [IN_TUSER_W-1:0]  s_tuser;   // [1:0] kind
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;   // [3:0] pitch_class, [10:4] midi_note
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [OCT_W-1:0]       cfg_data;

    // predicted state of the block
    logic [FRAC:0]          weights [CLASSES][CLASSES];
    logic                   learning;
    logic                   have_prev;
    logic [3:0]             prev_class;
    logic [3:0]             last_class;
    logic [OCT_W-1:0]       octave_now;

    t_pick expected_picks [$];
    int    errors        = 0;
    int    active_items  = 0;
    bit    gaps_on       = 1'b1;
    int    holds_wanted  = 0;
    int    holds_given   = 0;

    markov_note_learner_sampler_core #(
        .CLASSES       (CLASSES),
        .FRACTION_BITS (FRAC)
    ) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // learn from one accepted transaction and work out the pick it causes, if any
    task automatic apply_event(input t_note_event ev, output logic took,
                               output logic produced, output t_pick pick);
        int row, col, cls, oct;
        longint unsigned tot, acc, target;
        took     = 1'b0;
        produced = 1'b0;
        pick     = '0;
        case (ev.kind)
            KIND_RECORD: begin
                // note-offs and anything outside a recording are dropped
                if (learning && ev.vel != 0) begin
                    took = 1'b1;
                    cls  = ev.note % CLASSES;
                    if (ev.note == BREAK_NOTE) begin
                        have_prev = 1'b0;
                    end else begin
                        if (have_prev && weights[prev_class][cls] < COUNT_MAX)
                            weights[prev_class][cls] = weights[prev_class][cls] + 1'b1;
                        prev_class = 4'(cls);
                        have_prev  = 1'b1;
                    end
                end
            end
            KIND_START: begin
                took = 1'b1;
                foreach (weights[r, c]) weights[r][c] = '0;
                learning   = 1'b1;
                have_prev  = 1'b0;
                prev_class = '0;
            end
            KIND_FINISH: begin
                if (learning) begin
                    took     = 1'b1;
                    learning = 1'b0;
                    // counts to fractions of the row total, rounded half up
                    for (int r = 0; r < CLASSES; r++) begin
                        tot = 0;
                        for (int c = 0; c < CLASSES; c++) tot += weights[r][c];
                        if (tot == 0) begin
                            weights[r][0] = (FRAC+1)'(ONE_Q);
                        end else begin
                            for (int c = 0; c < CLASSES; c++)
                                weights[r][c] = (FRAC+1)'(((longint'(weights[r][c]) << FRAC)
                                                           + tot / 2) / tot);
                        end
                    end
                end
            end
            default: begin
                if (!learning) begin
                    took     = 1'b1;
                    produced = 1'b1;
                    target   = (longint'(ev.rnd) << FRAC) >> RAND_W;
                    if (ev.heard) row = (ev.vel != 0) ? ev.note % CLASSES : 0;
                    else row = last_class;
                    col = 0;
                    acc = 0;
                    while (col < CLASSES && acc + weights[row][col] < target) begin
                        acc += weights[row][col];
                        col++;
                    end
                    oct        = (octave_now == 0) ? 1 : octave_now;
                    last_class = 4'(col % CLASSES);
                    pick.pc    = PC_OUT_W'(col);
                    pick.midi  = MIDI_W'(col + oct * CLASSES);
                end
            end
        endcase
    endtask

    function automatic t_note_event make_event(t_kind k, int n, int v, int h, int r);
        t_note_event ev;
        ev.kind  = k;
        ev.note  = NOTE_W'(n);
        ev.vel   = VEL_W'(v);
        ev.heard = h[0];
        ev.rnd   = RAND_W'(r);
        return ev;
    endfunction

    function automatic t_plan_row plan_row(t_kind k, int n, int v, int h, int r,
                                           int typed, int pc, int midi);
        t_plan_row row;
        row.ev        = make_event(k, n, v, h, r);
        row.typed     = typed[0];
        row.want.pc   = PC_OUT_W'(pc);
        row.want.midi = MIDI_W'(midi);
        return row;
    endfunction

    // drive one transaction from the falling edge and hold it until it is taken
    task automatic offer(input t_note_event ev, input logic typed = 1'b0,
                         input t_pick want = '0);
        logic  took, produced;
        t_pick pick;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, ev.rnd, ev.heard, ev.vel, ev.note};
        s_tuser  <= ev.kind;
        do @(posedge clk); while (!s_tready);
        apply_event(ev, took, produced, pick);
        if (produced) expected_picks.push_back(typed ? want : pick);
        if (took) active_items++;
    endtask

    // random idle cycles on the input side, mostly short, now and then long
    task automatic sender_gap();
        int n;
        if (gaps_on && $urandom_range(99) < 29) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 1);
            repeat (n) begin
                @(negedge clk);
                s_tvalid <= 1'b0;
            end
        end
    endtask

    // stop offering, wait for every pick, then let a finish pass run out
    task automatic wait_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_picks.size() != 0) @(posedge clk);
        repeat (QUIET) @(posedge clk);
    endtask

    task automatic set_octave(input logic [OCT_W-1:0] oct);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= oct;
        do @(posedge clk); while (!cfg_ready);
        octave_now = oct;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // result side: random back-pressure, plus one long hold-off when asked for
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge clk);
            if (holds_wanted > holds_given) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                holds_given++;
            end else begin
                m_tready <= !gaps_on || ($urandom_range(99) >= 29);
            end
        end
    end

    // result checker: every accepted result against the oldest expected pick
    always @(posedge clk) begin
        t_pick want;
        if (rst_n && m_tvalid && m_tready) begin
            if (expected_picks.size() == 0) begin
                $error("unexpected result: pitch_class %0d midi_note %0d",
                       m_tdata[3:0], m_tdata[10:4]);
                errors++;
            end else begin
                want = expected_picks.pop_front();
                if (m_tdata[3:0] !== want.pc) begin
                    $error("pitch_class: expected %0d, got %0d", want.pc, m_tdata[3:0]);
                    errors++;
                end
                if (m_tdata[10:4] !== want.midi) begin
                    $error("midi_note: expected %0d, got %0d", want.midi, m_tdata[10:4]);
                    errors++;
                end
            end
        end
    end

    // stimulus and end of run
    initial begin
        t_plan_row              plan [24];
        t_note_event            ev;
        logic [3:0]             palette [CLASSES];
        logic [OCT_W-1:0]       oct_pick;
        int                     sess, pal_size, n_rec, n_play, k;

        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;

        // state after reset: every row holds the preset weights
        foreach (weights[r, c])
            weights[r][c] = (c == 4) ? (FRAC+1)'(ONE_Q / 2) :
                            (c == 1 || c == 10 || c == 11) ? (FRAC+1)'((ONE_Q * 5 + 50) / 100) :
                            (FRAC+1)'((ONE_Q * 10 + 50) / 100);
        learning   = 1'b0;
        have_prev  = 1'b0;
        prev_class = '0;
        last_class = '0;
        octave_now = OCTAVE_RESET;

        plan = '{
            // preset rows: cumulative 6554, 9831, ..., 55707 at class 4, 68815 at class 6
            plan_row(KIND_PLAY,     0,   0, 0,     0, 1, 0, 48),
            plan_row(KIND_PLAY,     0,   0, 0, 65535, 1, 6, 54),
            plan_row(KIND_PLAY,   127, 127, 1,  6555, 1, 1, 49),
            // heard but silent: row 0
            plan_row(KIND_PLAY,     5,   0, 1, 55707, 1, 4, 52),
            // record and finish outside a recording are dropped
            plan_row(KIND_RECORD,  60, 100, 0,     0, 0, 0, 0),
            plan_row(KIND_FINISH,   0,   0, 0,     0, 0, 0, 0),
            plan_row(KIND_START,    0,   0, 0,     0, 0, 0, 0),
            // play during recording is dropped
            plan_row(KIND_PLAY,     0,   0, 0,  1234, 0, 0, 0),
            plan_row(KIND_RECORD,  60, 127, 0,     0, 0, 0, 0),
            plan_row(KIND_RECORD,  62,   0, 0,     0, 0, 0, 0),
            plan_row(KIND_RECORD,  61,   1, 0,     0, 0, 0, 0),
            plan_row(KIND_RECORD,  60,  64, 0,     0, 0, 0, 0),
            // break note, then a note with no predecessor
            plan_row(KIND_RECORD,  21,  50, 0,     0, 0, 0, 0),
            plan_row(KIND_RECORD,  64,  64, 1, 65535, 0, 0, 0),
            plan_row(KIND_RECORD,  60,  64, 0,     0, 0, 0, 0),
            // start again while recording wipes it all
            plan_row(KIND_START,  127, 127, 1, 65535, 0, 0, 0),
            plan_row(KIND_RECORD,  60,  90, 0,     0, 0, 0, 0),
            plan_row(KIND_RECORD,  67,  90, 0,     0, 0, 0, 0),
            plan_row(KIND_RECORD,  21,   1, 0,     0, 0, 0, 0),
            plan_row(KIND_FINISH,   0,   0, 0,     0, 0, 0, 0),
            // row 0 is all class 7 now; the empty rows put everything on class 0
            plan_row(KIND_PLAY,    72,   1, 1, 65535, 1, 7, 55),
            plan_row(KIND_PLAY,    61,   9, 1, 65535, 1, 0, 48),
            plan_row(KIND_PLAY,     0,   0, 0,     0, 1, 0, 48),
            plan_row(KIND_PLAY,   100, 127, 0, 65535, 0, 0, 0)
        };

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i]) begin
            sender_gap();
            offer(plan[i].ev, plan[i].typed, plan[i].want);
        end

        active_items = 0;
        sess = 0;
        while (active_items < RANDOM_ITEMS) begin
            // octave only changes with the block idle
            wait_idle();
            case (sess)
                0:       oct_pick = 3'd7;
                1:       oct_pick = OCTAVE_MIN;
                2:       oct_pick = 3'd0;
                default: oct_pick = OCT_W'($urandom_range(7));
            endcase
            set_octave(oct_pick);
            // sessions 3 and 4 run with no idling on either side
            gaps_on = !(sess == 3 || sess == 4);

            if (sess % 5 == 4) begin
                // noise: any kind, any field values, in any order
                repeat (40) begin
                    ev = make_event(t_kind'($urandom_range(3)), $urandom, $urandom,
                                    $urandom, $urandom);
                    sender_gap();
                    offer(ev);
                end
            end else begin
                // a small set of pitch classes so rows build up repeated transitions
                pal_size = $urandom_range(CLASSES, 2);
                foreach (palette[i]) palette[i] = 4'($urandom_range(CLASSES - 1));
                sender_gap();
                offer(make_event(KIND_START, $urandom, $urandom, $urandom, $urandom));
                n_rec = $urandom_range(60, 8);
                repeat (n_rec) begin
                    k  = $urandom_range(99);
                    ev = make_event(KIND_RECORD, 0, $urandom_range(127, 1), $urandom,
                                    $urandom);
                    if (k < 5) begin
                        ev.note = BREAK_NOTE;
                    end else if (k < 10) begin
                        ev.note = NOTE_W'($urandom);
                        ev.vel  = '0;
                    end else if (k < 15) begin
                        ev.note = NOTE_W'($urandom);
                    end else begin
                        ev.note = NOTE_W'(CLASSES * $urandom_range(9)
                                          + palette[$urandom_range(pal_size - 1)]);
                    end
                    sender_gap();
                    offer(ev);
                end
                sender_gap();
                offer(make_event(KIND_FINISH, $urandom, $urandom, $urandom, $urandom));

                // once, the result side stops for a long stretch while plays keep coming
                if (sess == 1) holds_wanted++;
                n_play = $urandom_range(60, 15);
                for (int i = 0; i < n_play; i++) begin
                    // once, the input side waits for every outstanding pick
                    if (sess == 0 && i == n_play / 2) wait_idle();
                    k  = $urandom_range(99);
                    ev = make_event(KIND_PLAY, $urandom, $urandom,
                                    $urandom_range(99) < 40, $urandom);
                    if ($urandom_range(99) < 15) ev.vel = '0;
                    // top values find rows whose rounded weights fall short of 1.0
                    if (k < 10) ev.rnd = '1;
                    else if (k < 15) ev.rnd = RAND_W'($urandom_range(65535, 65520));
                    else if (k < 20) ev.rnd = '0;
                    sender_gap();
                    offer(ev);
                end
            end
            sess++;
        end

        // one pair repeated back to back, then its row played
        wait_idle();
        gaps_on = 1'b0;
        offer(make_event(KIND_START, 0, 0, 0, 0));
        repeat (PAIR_REPEATS) offer(make_event(KIND_RECORD, 60, 100, 0, 0));
        offer(make_event(KIND_RECORD, 61, 100, 0, 0));
        offer(make_event(KIND_FINISH, 0, 0, 0, 0));
        offer(make_event(KIND_PLAY, 60, 100, 1, 65535));
        offer(make_event(KIND_PLAY, 60, 100, 1, 1));
        offer(make_event(KIND_PLAY, 0, 0, 0, $urandom));

        wait_idle();
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // hard stop well beyond the slowest correct run
    initial begin
        #40_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
